>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tone sequence validator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define TSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tone sequence validator: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define TSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tone sequence validator: next-cycle check failed");

`endif

>>> rtl/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Widths, codes and helper functions of the tone sequence validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsv_pkg;

  localparam int OP_W   = 2;
  localparam int TONE_W = 5;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Event codes on the input channel.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_TONE  = 2'd1;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd2;

  // Register indexes, selected by paddr[2].
  localparam logic REG_MIN_TONES = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  localparam logic [6:0] MIN_TONES_RST = 7'd5;
  localparam logic [7:0] TOLERANCE_RST = 8'd3;

  localparam logic [7:0] REPEAT_CODE  = 8'h0E;
  localparam logic [7:0] INVALID_TONE = 8'h61;
  localparam logic [7:0] COUNT_MAX    = 8'hFF;
  localparam logic [7:0] MAX_RESULTS  = 8'd16;

  localparam logic [7:0] ASCII_LETTER = 8'h37;
  localparam logic [7:0] ASCII_DIGIT  = 8'h30;
  localparam logic [7:0] DIGIT_MAX    = 8'h09;
  localparam logic [7:0] HEX_MAX      = 8'h0F;

  // Hex digit of a tone number; values outside 10..15 take the digit offset.
  function automatic logic [7:0] tone_to_ascii(input logic [7:0] tone);
    if (tone > DIGIT_MAX && tone <= HEX_MAX) begin
      return tone + ASCII_LETTER;
    end
    return tone + ASCII_DIGIT;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tsv_in_if.sv
// ----------------------------------------------------------------------------
// tsv_in_if
// Decoder event channel: valid/ready handshake with op and tone code.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsv_in_if;
  import tsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TONE_W-1:0] tone_code;

  modport source (output valid, output op, output tone_code, input ready);
  modport sink   (input valid, input op, input tone_code, output ready);
endinterface

`default_nettype wire

>>> rtl/tsv_out_if.sv
// ----------------------------------------------------------------------------
// tsv_out_if
// Character channel: valid/ready handshake with a character and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsv_out_if;
  import tsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] seq_char;
  logic              last_char;

  modport source (output valid, output seq_char, output last_char, input ready);
  modport sink   (input valid, input seq_char, input last_char, output ready);
endinterface

`default_nettype wire

>>> rtl/tone_sequence_validator_unit.sv
// Tick and tone events are handled without leaving the idle state, so the unit stays ready.
// A no-tone event that meets the tone count scans the stored durations from slot 2 to N-1
// (N = stored tones, at most SEQ_DEPTH, one duration RAM read per cycle), checks them, then
// reads, loads and emits each character, holding on output stall; otherwise it stays idle.
// Reset restores the register defaults, clears the counters and the duration valid bits;
// the stores need no clearing pass.
// ----------------------------------------------------------------------------
// tone_sequence_validator_unit
// Collects decoded tones into a sequence and emits it once its timing checks out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tone_sequence_validator_unit #(
  parameter int SEQ_DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tsv_in_if.sink                           evt_i,
  tsv_out_if.source                        char_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tsv_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tsv_pkg::DATA_W-1:0]  pwdata,
  output logic      [tsv_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import tsv_pkg::*;

  localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int CW = $clog2(SEQ_DEPTH + 1);
  localparam logic [CW-1:0] SCAN_FIRST = CW'(2);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_CHECK     = 3'd2;
  localparam logic [2:0] ST_EMIT_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT_LD   = 3'd4;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [6:0]           min_tones_q;
  logic [7:0]           tol_q;
  logic [7:0]           prev_tone_q, prev_tone_d;
  logic [7:0]           tone_cnt_q, tone_cnt_d;
  logic [7:0]           tick_cnt_q, tick_cnt_d;
  logic [SEQ_DEPTH-1:0] dur_vld_q, dur_vld_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;

  logic [CW-1:0]        idx_q, idx_d;
  logic                 pend_vld_q;
  logic [7:0]           lo_q, lo_d;
  logic [7:0]           hi_q, hi_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  logic                 in_acc, out_acc, cfg_wr;
  logic [7:0]           code_ext, tone_res;
  logic                 tone_new, slot_ok;
  logic [AW-1:0]        slot, rd_addr;
  logic [7:0]           seq_n8, emit_n8, dur_val;
  logic [CW-1:0]        scan_n, emit_n;
  logic                 dur_we, chr_we, dur_re, chr_re;
  logic [7:0]           dur_rdata, chr_rdata;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tones_q <= MIN_TONES_RST;
      tol_q       <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_TONES: min_tones_q <= pwdata[6:0];
        REG_TOLERANCE: tol_q       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_TONES: prdata = {25'd0, min_tones_q};
      REG_TOLERANCE: prdata = {24'd0, tol_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign evt_i.ready = (state_q == ST_IDLE);
  assign in_acc      = evt_i.valid && evt_i.ready;
  assign out_acc     = out_valid_q && char_o.ready;

  assign code_ext = {3'd0, evt_i.tone_code};
  assign tone_new = (code_ext != prev_tone_q);
  assign tone_res = (code_ext == REPEAT_CODE) ? prev_tone_q : code_ext;

  assign slot_ok = (tone_cnt_q < 8'(SEQ_DEPTH));
  assign slot    = tone_cnt_q[AW-1:0];

  // Number of stored slots, and of characters that go out.
  assign seq_n8  = slot_ok ? tone_cnt_q : 8'(SEQ_DEPTH);
  assign emit_n8 = (seq_n8 > MAX_RESULTS) ? MAX_RESULTS : seq_n8;
  assign scan_n  = seq_n8[CW-1:0];
  assign emit_n  = emit_n8[CW-1:0];

  assign rd_addr = idx_q[AW-1:0];
  // A duration slot that was never written since reset reads as zero.
  assign dur_val = pend_vld_q ? dur_rdata : 8'd0;

  tsv_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_DEPTH)
  ) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (dur_we),
    .waddr_i (slot),
    .wdata_i (tick_cnt_d),
    .re_i    (dur_re),
    .raddr_i (rd_addr),
    .rdata_o (dur_rdata)
  );

  tsv_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (SEQ_DEPTH)
  ) u_chr_ram (
    .clk_i   (clk_i),
    .we_i    (chr_we),
    .waddr_i (slot),
    .wdata_i (tone_to_ascii(tone_res)),
    .re_i    (chr_re),
    .raddr_i (rd_addr),
    .rdata_o (chr_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    prev_tone_d = prev_tone_q;
    tone_cnt_d  = tone_cnt_q;
    tick_cnt_d  = tick_cnt_q;
    dur_vld_d   = dur_vld_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    dur_we      = 1'b0;
    chr_we      = 1'b0;
    dur_re      = 1'b0;
    chr_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (evt_i.op)
            OP_TICK: begin
              tick_cnt_d = tick_cnt_q + 8'd1;
              if (slot_ok) begin
                dur_we          = 1'b1;
                dur_vld_d[slot] = 1'b1;
              end
            end
            OP_TONE: begin
              if (tone_new) begin
                tick_cnt_d  = 8'd0;
                prev_tone_d = tone_res;
                chr_we      = slot_ok;
                if (tone_cnt_q != COUNT_MAX) begin
                  tone_cnt_d = tone_cnt_q + 8'd1;
                end
              end
            end
            OP_NONE: begin
              if (tone_cnt_q >= {1'b0, min_tones_q}) begin
                idx_d   = SCAN_FIRST;
                lo_d    = 8'hFF;
                hi_d    = 8'h00;
                state_d = ST_SCAN;
              end else begin
                prev_tone_d = INVALID_TONE;
                tone_cnt_d  = 8'd0;
              end
            end
            default: ;
          endcase
        end
      end

      // One read issued per cycle; the compare on its data follows in the next cycle.
      ST_SCAN: begin
        if (pend_q) begin
          if (dur_val < lo_q) begin
            lo_d = dur_val;
          end
          if (dur_val > hi_q) begin
            hi_d = dur_val;
          end
        end
        if (idx_q < scan_n) begin
          dur_re = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + CW'(1);
        end else if (!pend_q) begin
          state_d = ST_CHECK;
        end
      end

      // With no middle tones hi stays below lo, which counts as a pass.
      ST_CHECK: begin
        idx_d = '0;
        if (((hi_q < lo_q) || ((hi_q - lo_q) <= tol_q)) && (emit_n != '0)) begin
          state_d = ST_EMIT_RD;
        end else begin
          prev_tone_d = INVALID_TONE;
          tone_cnt_d  = 8'd0;
          state_d     = ST_IDLE;
        end
      end

      ST_EMIT_RD: begin
        chr_re  = 1'b1;
        state_d = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_char_d  = chr_rdata;
        out_last_d  = ((idx_q + CW'(1)) == emit_n);
        out_valid_d = 1'b1;
        idx_d       = idx_q + CW'(1);
        state_d     = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            prev_tone_d = INVALID_TONE;
            tone_cnt_d  = 8'd0;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_tone_q <= REPEAT_CODE;
      tone_cnt_q  <= 8'd0;
      tick_cnt_q  <= 8'd0;
      dur_vld_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_tone_q <= prev_tone_d;
      tone_cnt_q  <= tone_cnt_d;
      tick_cnt_q  <= tick_cnt_d;
      dur_vld_q   <= dur_vld_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pend_vld_q <= dur_vld_q[rd_addr];
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign char_o.valid     = out_valid_q;
  assign char_o.seq_char  = out_char_q;
  assign char_o.last_char = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TSV_ASSERT_IMP(a_out_only_in_emit, clk_i, rst_ni, out_valid_q, state_q == ST_EMIT_WAIT)
  `TSV_ASSERT_NXT(a_last_clears_seq, clk_i, rst_ni, out_acc && out_last_q,
                  (state_q == ST_IDLE) && (tone_cnt_q == 8'd0) && !out_valid_q)
  `TSV_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == ST_SCAN,
                  (idx_q <= scan_n) || (idx_q == SCAN_FIRST))
  `TSV_ASSERT_IMP(a_emit_in_range, clk_i, rst_ni,
                  (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_LD), idx_q < emit_n)

endmodule

`default_nettype wire

>>> rtl/tsv_ram.sv
// ----------------------------------------------------------------------------
// tsv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
